@@ rtl/ita_pkg.sv @@
// ita_pkg: shared types, codes and character helpers for the integer to ASCII
// formatter. No dependencies; imported by ita_bcd_step and the top level.
package ita_pkg;

  // operation codes on in_operation (code 3 is undefined and yields no text)
  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;

  // bits of the binary value folded into the BCD register per cycle
  localparam int unsigned BITS_PER_STEP = 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_A_LOW = 8'h61;  // 'a'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PFX,
    ST_EMIT
  } ita_state_t;

  // ASCII for one digit, 0-9 then lower-case a-f
  function automatic logic [7:0] ita_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_A_LOW + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

@@ rtl/ita_bcd_step.sv @@
// ita_bcd_step: shared shift-and-add-3 unit; folds BITS_PER_STEP binary bits
// (msb first) into a packed BCD register. Depends on ita_pkg.
module ita_bcd_step #(
  parameter int unsigned NDIG = 20
) (
  input  logic [NDIG*4-1:0]                   bcd_in,
  input  logic [ita_pkg::BITS_PER_STEP-1:0]   bits_in,
  output logic [NDIG*4-1:0]                   bcd_out
);
  import ita_pkg::*;

  always_comb begin
    logic [NDIG*4-1:0] acc;
    acc = bcd_in;
    for (int k = BITS_PER_STEP - 1; k >= 0; k--) begin
      // digits are independent here; only the shift links them
      for (int d = 0; d < NDIG; d++) begin
        if (acc[d*4 +: 4] >= 4'd5) begin
          acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
        end
      end
      acc = {acc[NDIG*4-2:0], bits_in[k]};
    end
    bcd_out = acc;
  end

endmodule

@@ rtl/integer_to_ascii_formatter.sv @@
// integer_to_ascii_formatter: formats one number as ASCII text, one character
// per output beat, most significant first.
//
// Input: pulse start with in_value and in_operation while busy is low; the beat
// is taken at that edge and, for codes 0 to 2, busy rises on the next cycle.
// in_operation selects unsigned decimal, signed decimal ('-' then magnitude) or
// hex with "0x" prefix. Operation code 3 is accepted and produces no text. Only
// the low VALUE_WIDTH bits of in_value are used.
// Output: each character appears on out_character for exactly one cycle with
// out_valid high; out_last marks the final character. The receiver cannot stall.
// Sequence: decimal first folds the value through the shared shift-add-3 unit
// (four bits per cycle), then both modes drop leading zero digits, keeping at
// least one, then send the prefix if any and the digits. Hex skips the folding
// and starts at the zero drop. The next start is taken as busy falls.
// Reset: synchronous, active low; returns to idle, drops busy and out_valid.
module integer_to_ascii_formatter #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [63:0] in_value,
  input  logic [1:0] in_operation,
  output logic       out_valid,
  output logic [7:0] out_character,
  output logic       out_last
);
  import ita_pkg::*;

  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned NSTEP = (VW + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned PADW  = NSTEP * BITS_PER_STEP;
  localparam int unsigned NDEC  = (VW * 30103) / 100000 + 1;
  localparam int unsigned NDIG  = (NDEC > NSTEP) ? NDEC : NSTEP;
  localparam int unsigned DW    = NDIG * 4;
  localparam int unsigned CNTW  = $clog2(NDIG + 1);
  localparam int unsigned SW    = $clog2(NSTEP);

  ita_state_t state_r, state_nxt;

  logic [PADW-1:0] mag_r, mag_nxt;
  logic [DW-1:0]   dig_r, dig_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]   step_r, step_nxt;
  logic [1:0]      pfx_r, pfx_nxt;
  logic            hex_r, hex_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_character_r, out_character_nxt;
  logic            out_last_r, out_last_nxt;

  logic [VW-1:0]   in_v;
  logic            in_neg;
  logic [VW-1:0]   in_mag;
  logic [DW-1:0]   bcd_next;
  logic [3:0]      top_dig;
  logic            accept;

  assign accept  = start && (state_r == ST_IDLE);
  assign in_v    = in_value[VW-1:0];
  assign in_neg  = (in_operation == OP_SDEC) && in_v[VW-1];
  // the most negative value negates to itself, read unsigned as 2^(VW-1)
  assign in_mag  = in_neg ? (~in_v + VW'(1)) : in_v;
  assign top_dig = dig_r[DW-1 -: 4];

  ita_bcd_step #(
    .NDIG(NDIG)
  ) u_bcd_step (
    .bcd_in (dig_r),
    .bits_in(mag_r[PADW-1 -: BITS_PER_STEP]),
    .bcd_out(bcd_next)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_HEX) begin
            state_nxt = ST_SKIP;
          end else if (in_operation == OP_UDEC || in_operation == OP_SDEC) begin
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (step_r == '0) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (!(cnt_r > CNTW'(1) && top_dig == 4'd0)) begin
          state_nxt = (pfx_r != 2'd0) ? ST_PFX : ST_EMIT;
        end
      end
      ST_PFX: begin
        if (pfx_r == 2'd1) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cnt_r == CNTW'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mag_nxt           = mag_r;
    dig_nxt           = dig_r;
    cnt_nxt           = cnt_r;
    step_nxt          = step_r;
    pfx_nxt           = pfx_r;
    hex_nxt           = hex_r;
    out_valid_nxt     = 1'b0;
    out_character_nxt = out_character_r;
    out_last_nxt      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mag_nxt  = PADW'(in_mag);
          step_nxt = SW'(NSTEP - 1);
          hex_nxt  = (in_operation == OP_HEX);
          if (in_operation == OP_HEX) begin
            // hex digits are the nibbles themselves, aligned to the top
            dig_nxt = {PADW'(in_mag), {(DW - PADW){1'b0}}};
            cnt_nxt = CNTW'(NSTEP);
            pfx_nxt = 2'd2;
          end else begin
            dig_nxt = '0;
            cnt_nxt = CNTW'(NDEC);
            pfx_nxt = in_neg ? 2'd1 : 2'd0;
          end
        end
      end
      ST_CONV: begin
        dig_nxt  = bcd_next;
        mag_nxt  = mag_r << BITS_PER_STEP;
        step_nxt = step_r - SW'(1);
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (cnt_r > CNTW'(1) && top_dig == 4'd0) begin
          dig_nxt = dig_r << 4;
          cnt_nxt = cnt_r - CNTW'(1);
        end
      end
      ST_PFX: begin
        out_valid_nxt = 1'b1;
        if (hex_r) begin
          out_character_nxt = (pfx_r == 2'd2) ? CH_ZERO : CH_X;
        end else begin
          out_character_nxt = CH_MINUS;
        end
        pfx_nxt = pfx_r - 2'd1;
      end
      ST_EMIT: begin
        out_valid_nxt     = 1'b1;
        out_character_nxt = ita_char(top_dig);
        out_last_nxt      = (cnt_r == CNTW'(1));
        dig_nxt           = dig_r << 4;
        cnt_nxt           = cnt_r - CNTW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r           <= mag_nxt;
    dig_r           <= dig_nxt;
    cnt_r           <= cnt_nxt;
    step_r          <= step_nxt;
    pfx_r           <= pfx_nxt;
    hex_r           <= hex_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule

@@ dv/tb.sv @@
// tb: self-checking bench for integer_to_ascii_formatter; predicts the text of
// every number it sends and checks each character beat. Depends on rtl/ita_pkg.sv.
`timescale 1ns / 1ps

module tb;
  import ita_pkg::*;

  localparam int unsigned VW = 64;
  localparam logic [1:0] OP_NONE = 2'd3;  // undefined code, no text expected
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  op;
    logic        hold_for_drain;  // wait for all pending text before sending
  } number_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_value = '0;
  logic [1:0]  in_operation = OP_UDEC;
  logic        out_valid;
  logic [7:0]  out_character;
  logic        out_last;

  number_item_t pending_numbers[$];
  text_beat_t   expected_text[$];
  number_item_t next_number;
  text_beat_t   want;
  logic         in_taken = 1'b0;
  int           total_numbers = 0;
  int           numbers_taken = 0;
  int           idle_cycles = 0;
  int           mismatches = 0;

  integer_to_ascii_formatter #(.VALUE_WIDTH(VW)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // Expected characters of one number, appended to expected_text
  function automatic void format_expected(input logic [63:0] raw, input logic [1:0] op);
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    int unsigned base;
    int unsigned d;
    mask = (VW >= 64) ? {64{1'b1}} : ((64'd1 << VW) - 64'd1);
    v = raw & mask;
    mag = v;
    base = 10;
    case (op)
      OP_UDEC: ;
      OP_SDEC: begin
        if (v[VW-1]) begin
          mag = (~v + 64'd1) & mask;
          text.push_back(CH_MINUS);
        end
      end
      OP_HEX: begin
        base = 16;
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
      end
      default: return;
    endcase
    do begin
      d = 32'(mag % 64'(base));
      digits.push_front(d < 10 ? CH_ZERO + 8'(d) : CH_A_LOW + 8'(d - 10));
      mag = mag / 64'(base);
    end while (mag != 64'd0);
    foreach (digits[i]) text.push_back(digits[i]);
    foreach (text[i]) expected_text.push_back('{text[i], i == text.size() - 1});
  endfunction

  task automatic add_number(input logic [63:0] value, input logic [1:0] op,
                            input logic hold = 1'b0);
    pending_numbers.push_back('{value, op, hold});
  endtask

  // driver: new beat only when the line is free or the last one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_taken) begin
      if (pending_numbers.size() == 0) begin
        start <= 1'b0;
      end else if (pending_numbers[0].hold_for_drain && expected_text.size() != 0) begin
        start <= 1'b0;
      end else if ($urandom_range(0, 99) < ((numbers_taken < total_numbers / 3) ? 23 :
                   (numbers_taken < 2 * total_numbers / 3) ? 73 : 0)) begin
        start <= 1'b0;
      end else begin
        next_number = pending_numbers.pop_front();
        in_value <= next_number.value;
        in_operation <= next_number.op;
        start <= 1'b1;
      end
    end
  end

  // monitor: input acceptance, result checks and the stall counter
  always @(posedge clk) begin
    in_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy) begin
        format_expected(in_value, in_operation);
        numbers_taken++;
      end
      if (out_valid) begin
        if (expected_text.size() == 0) begin
          $error("unexpected beat: character %h last %b", out_character, out_last);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (out_character !== want.character) begin
            $error("character: expected %h, got %h", want.character, out_character);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            mismatches++;
          end
        end
      end
      idle_cycles = ((start && !busy) || out_valid) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0] pw;
    logic [63:0] v;
    logic [1:0]  op;
    int          k;

    // directed: extremes, every operation, undefined code, most negative value
    add_number(64'd0, OP_UDEC);
    add_number(64'd0, OP_SDEC);
    add_number(64'd0, OP_HEX);
    add_number({64{1'b1}}, OP_UDEC);
    add_number({64{1'b1}}, OP_SDEC);
    add_number({64{1'b1}}, OP_HEX);
    add_number(64'h8000_0000_0000_0000, OP_SDEC);
    add_number(64'h8000_0000_0000_0000, OP_UDEC);
    add_number(64'h7fff_ffff_ffff_ffff, OP_SDEC);
    add_number(64'h7fff_ffff_ffff_ffff, OP_HEX);
    add_number(64'd1, OP_SDEC);
    add_number(64'd9, OP_UDEC);
    add_number(64'd10, OP_UDEC);
    add_number(64'd15, OP_HEX);
    add_number(64'd16, OP_HEX);
    add_number(64'd10000000000000000000, OP_UDEC);
    add_number(64'd9999999999999999999, OP_UDEC);
    add_number(64'hffff_ffff_ffff_fff6, OP_SDEC);
    add_number(64'h1234_5678_9abc_def0, OP_NONE);
    add_number(64'd0, OP_NONE, 1'b1);
    add_number(64'hdead_beef_0bad_f00d, OP_HEX, 1'b1);

    for (int n = 0; n < 309; n++) begin
      case ($urandom_range(0, 5))
        0, 1: v = {$urandom, $urandom};
        2: v = 64'($urandom_range(0, 1000));
        3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        4: begin
          k = $urandom_range(0, 19);
          pw = 64'd1;
          repeat (k) pw = pw * 64'd10;
          v = pw + 64'($urandom_range(0, 2)) - 64'd1;
        end
        default: v = -64'($urandom_range(1, 100000));
      endcase
      op = ($urandom_range(0, 99) < 5) ? OP_NONE : 2'($urandom_range(0, 2));
      add_number(v, op, $urandom_range(0, 99) < 3);
    end
    total_numbers = pending_numbers.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (!(numbers_taken == total_numbers && expected_text.size() == 0)
           && idle_cycles < IDLE_LIMIT)
      @(negedge clk);

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (mismatches == 0 && expected_text.size() == 0) begin
        $display("tb: PASS");
      end else begin
        $display("tb: FAIL");
      end
    end
    $finish;
  end

endmodule
